>>> design/drtt_pkg.sv
// drtt_pkg: shared types, codes and constants of the dma read tag tracker
// used by drtt_ctrl, drtt_datapath and dma_read_tag_tracker_unit
// no dependencies
`default_nettype none

package drtt_pkg;

    // tag table depth, a power of two no larger than the 8-bit tag fields
    localparam int TAG_COUNT = 256;
    localparam int TAG_W     = $clog2(TAG_COUNT);

    localparam int HOST_ADDR_W = 64;
    localparam int COUNT_W     = 7;
    localparam int ADDR_W      = 32;
    localparam int BUF_ID_W    = 10;
    localparam int FIELD_TAG_W = 8;

    localparam logic [ADDR_W-1:0] OFFSET_BIAS = 32'd256;

    // input function codes
    localparam logic FUNC_REQUEST = 1'b0;
    localparam logic FUNC_STATUS  = 1'b1;

    // result kind codes
    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_NOTIF   = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    typedef struct packed {
        logic take_req;
        logic take_sts;
        logic load_notif;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic [BUF_ID_W-1:0] buffer_id;
        logic [ADDR_W-1:0]   offset;
    } t_entry;

endpackage

`default_nettype wire

>>> design/drtt_ctrl.sv
// drtt_ctrl: controller of the tag tracker, sequences requests and lookups
// depends on drtt_pkg
`default_nettype none

module drtt_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_func,
    input  wire drtt_pkg::t_dp_status i_status,
    output drtt_pkg::t_dp_cmd        o_cmd,
    output logic                     o_in_stall
);

    drtt_pkg::t_state r_state;
    drtt_pkg::t_state n_state;
    logic             in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drtt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            drtt_pkg::S_IDLE: begin
                if (o_cmd.take_sts) begin
                    n_state = drtt_pkg::S_READ;
                end
            end
            drtt_pkg::S_READ: begin
                if (o_cmd.load_notif) begin
                    n_state = drtt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = drtt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready         = 1'b0;
        o_cmd.take_req   = 1'b0;
        o_cmd.take_sts   = 1'b0;
        o_cmd.load_notif = 1'b0;
        unique case (r_state)
            drtt_pkg::S_IDLE: begin
                // a word is taken whenever the output slot frees this cycle
                in_ready       = i_status.out_free;
                o_cmd.take_req = in_ready && i_in_valid && (i_func == drtt_pkg::FUNC_REQUEST);
                o_cmd.take_sts = in_ready && i_in_valid && (i_func == drtt_pkg::FUNC_STATUS);
            end
            drtt_pkg::S_READ: begin
                o_cmd.load_notif = i_status.out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign o_in_stall = !in_ready;

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.take_req && o_cmd.load_notif) && !(o_cmd.take_sts && o_cmd.load_notif))
        else $error("input taken while a lookup result is loaded");

    a_sts_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_sts |=> (r_state == drtt_pkg::S_READ))
        else $error("status word did not start a table read");

    a_read_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drtt_pkg::S_READ) |-> o_in_stall)
        else $error("input accepted during a table read");

endmodule

`default_nettype wire

>>> design/drtt_datapath.sv
// drtt_datapath: tag counter, pending tag table and result register
// depends on drtt_pkg, driven by drtt_ctrl commands
`default_nettype none

module drtt_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire drtt_pkg::t_dp_cmd                   i_cmd,
    output drtt_pkg::t_dp_status                     o_status,
    input  wire logic [drtt_pkg::HOST_ADDR_W-1:0]    i_host_addr,
    input  wire logic [drtt_pkg::COUNT_W-1:0]        i_byte_count,
    input  wire logic [drtt_pkg::ADDR_W-1:0]         i_msg_addr,
    input  wire logic [drtt_pkg::BUF_ID_W-1:0]       i_buffer_id,
    input  wire logic [drtt_pkg::ADDR_W-1:0]         i_buffer_size,
    input  wire logic [drtt_pkg::FIELD_TAG_W-1:0]    i_status_tag,
    input  wire logic                                i_out_stall,
    output logic                                     o_out_valid,
    output logic                                     o_kind,
    output logic [drtt_pkg::HOST_ADDR_W-1:0]         o_pcie_addr,
    output logic [drtt_pkg::ADDR_W-1:0]              o_ram_addr,
    output logic [drtt_pkg::COUNT_W-1:0]             o_length,
    output logic [drtt_pkg::FIELD_TAG_W-1:0]         o_cmd_tag,
    output logic [drtt_pkg::BUF_ID_W-1:0]            o_notif_buffer,
    output logic [drtt_pkg::ADDR_W-1:0]              o_buffered_offset
);

    drtt_pkg::t_entry                   r_table [drtt_pkg::TAG_COUNT];
    drtt_pkg::t_entry                   r_rd_entry;
    drtt_pkg::t_entry                   wr_entry;
    logic [drtt_pkg::TAG_W-1:0]         r_next_tag;
    logic [drtt_pkg::TAG_W-1:0]         n_next_tag;
    logic [drtt_pkg::TAG_W-1:0]         rd_tag;

    logic                               r_out_valid;
    logic                               r_kind;
    logic [drtt_pkg::HOST_ADDR_W-1:0]   r_pcie_addr;
    logic [drtt_pkg::ADDR_W-1:0]        r_ram_addr;
    logic [drtt_pkg::COUNT_W-1:0]       r_length;
    logic [drtt_pkg::FIELD_TAG_W-1:0]   r_cmd_tag;
    logic [drtt_pkg::BUF_ID_W-1:0]      r_notif_buffer;
    logic [drtt_pkg::ADDR_W-1:0]        r_buffered_offset;

    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign wr_entry.buffer_id = i_buffer_id;
    assign wr_entry.offset    = i_buffer_size - i_msg_addr - drtt_pkg::OFFSET_BIAS;

    // depth is a power of two, so the status tag reduces by dropping high bits
    assign rd_tag = i_status_tag[drtt_pkg::TAG_W-1:0];

    assign n_next_tag = (r_next_tag == drtt_pkg::TAG_W'(drtt_pkg::TAG_COUNT - 1))
                        ? '0 : r_next_tag + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_table[r_next_tag] <= wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_sts) begin
            r_rd_entry <= r_table[rd_tag];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_tag  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take_req) begin
                r_next_tag <= n_next_tag;
            end
            if (i_cmd.take_req || i_cmd.load_notif) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_kind            <= drtt_pkg::KIND_COMMAND;
            r_pcie_addr       <= i_host_addr;
            r_ram_addr        <= i_msg_addr;
            r_length          <= i_byte_count;
            r_cmd_tag         <= drtt_pkg::FIELD_TAG_W'(r_next_tag);
            r_notif_buffer    <= '0;
            r_buffered_offset <= '0;
        end else if (i_cmd.load_notif) begin
            r_kind            <= drtt_pkg::KIND_NOTIF;
            r_pcie_addr       <= '0;
            r_ram_addr        <= '0;
            r_length          <= '0;
            r_cmd_tag         <= '0;
            r_notif_buffer    <= r_rd_entry.buffer_id;
            r_buffered_offset <= r_rd_entry.offset;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_kind;
    assign o_pcie_addr       = r_pcie_addr;
    assign o_ram_addr        = r_ram_addr;
    assign o_length          = r_length;
    assign o_cmd_tag         = r_cmd_tag;
    assign o_notif_buffer    = r_notif_buffer;
    assign o_buffered_offset = r_buffered_offset;

endmodule

`default_nettype wire

>>> design/dma_read_tag_tracker_unit.sv
// dma_read_tag_tracker_unit: top level of the host-to-card dma read tag tracker
// depends on drtt_pkg, drtt_ctrl and drtt_datapath
//
//   channel | dir | handshake               | payload
//   in      | in  | i_in_valid / o_in_stall | func, host_addr, byte_count, msg_addr,
//           |     |                         | buffer_id, buffer_size, status_tag
//   out     | out | o_out_valid / i_out_stall | kind, pcie_addr, ram_addr, length,
//           |     |                         | cmd_tag, notif_buffer, buffered_offset
//
// a read request word lands in the output register at the accepting edge, so
// requests stream at one word per cycle while no stall or status read holds input
// a status word's tag table entry is registered, then loaded once the output frees
// reset (synchronous, active low) clears the tag counter and the output valid;
// tag table has no reset; the user must read only tags already written (unenforced)
// a full, stalled output register holds input off until the result is taken
`default_nettype none

module dma_read_tag_tracker_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_func,
    input  wire logic [drtt_pkg::HOST_ADDR_W-1:0]    i_host_addr,
    input  wire logic [drtt_pkg::COUNT_W-1:0]        i_byte_count,
    input  wire logic [drtt_pkg::ADDR_W-1:0]         i_msg_addr,
    input  wire logic [drtt_pkg::BUF_ID_W-1:0]       i_buffer_id,
    input  wire logic [drtt_pkg::ADDR_W-1:0]         i_buffer_size,
    input  wire logic [drtt_pkg::FIELD_TAG_W-1:0]    i_status_tag,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_kind,
    output logic [drtt_pkg::HOST_ADDR_W-1:0]         o_pcie_addr,
    output logic [drtt_pkg::ADDR_W-1:0]              o_ram_addr,
    output logic [drtt_pkg::COUNT_W-1:0]             o_length,
    output logic [drtt_pkg::FIELD_TAG_W-1:0]         o_cmd_tag,
    output logic [drtt_pkg::BUF_ID_W-1:0]            o_notif_buffer,
    output logic [drtt_pkg::ADDR_W-1:0]              o_buffered_offset
);

    drtt_pkg::t_dp_cmd    dp_cmd;
    drtt_pkg::t_dp_status dp_status;

    drtt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    drtt_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_status          (dp_status),
        .i_host_addr       (i_host_addr),
        .i_byte_count      (i_byte_count),
        .i_msg_addr        (i_msg_addr),
        .i_buffer_id       (i_buffer_id),
        .i_buffer_size     (i_buffer_size),
        .i_status_tag      (i_status_tag),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_kind            (o_kind),
        .o_pcie_addr       (o_pcie_addr),
        .o_ram_addr        (o_ram_addr),
        .o_length          (o_length),
        .o_cmd_tag         (o_cmd_tag),
        .o_notif_buffer    (o_notif_buffer),
        .o_buffered_offset (o_buffered_offset)
    );

endmodule

`default_nettype wire
